[design/assert_macros.svh]
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
	else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
	else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

[design/vmvp_pkg.sv]
// Package: constants and types for the vertex transform pipeline.
`default_nettype none
package vmvp_pkg;
	localparam int COORD_WIDTH_DEF = 16;
	localparam int COEF_WIDTH_DEF  = 16;
	localparam int NDC_FRAC        = 14;
	localparam int NUM_ROWS        = 4;
	localparam int DIV_STEPS       = 16;
	localparam logic [1:0] REG_ROW0 = 2'd0;
	localparam logic [1:0] REG_ROW1 = 2'd1;
	localparam logic [1:0] REG_ROW2 = 2'd2;
	localparam logic [1:0] REG_ROW3 = 2'd3;
	localparam logic [63:0] ROW0_RST = 64'd4096;
	localparam logic [63:0] ROW1_RST = 64'd268435456;
	localparam logic [63:0] ROW2_RST = 64'd17592186044416;
	localparam logic [63:0] ROW3_RST = 64'd1152921504606846976;
endpackage
`default_nettype wire

[design/vmvp_div.sv]
// Pipelined restoring divider: one quotient bit per stage, three lanes share w.
`default_nettype none
module vmvp_div #(
	parameter int NUM_W = 40
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [NUM_W-1:0] num_a [3],
	input  wire logic [NUM_W-1:0] den,
	input  wire logic [2:0]       neg,
	input  wire logic             fault,
	input  wire logic [31:0]      tex,
	output logic                  out_valid,
	output logic [2:0][15:0]      ndc,
	output logic                  sat,
	output logic                  fault_out,
	output logic [31:0]           tex_out
);
	localparam int S  = vmvp_pkg::DIV_STEPS;
	localparam int DW = NUM_W + S;

	// stage k holds partial remainder and quotient after k steps
	logic                    v_s   [S+1];
	logic [DW-1:0]           rem_s [S+1][3];
	logic [S-1:0]            q_s   [S+1][3];
	logic [NUM_W-1:0]        den_s [S+1];
	logic [2:0]              neg_s [S+1];
	logic                    flt_s [S+1];
	logic [31:0]             tex_s [S+1];
	// high part of num (beyond S-1 bits of quotient): overflow marks
	logic [2:0]              ovf_s [S+1];

	always_comb begin
		v_s[0]   = in_valid;
		den_s[0] = den;
		neg_s[0] = neg;
		flt_s[0] = fault;
		tex_s[0] = tex;
		for (int l = 0; l < 3; l++) begin
			rem_s[0][l] = {{(S - vmvp_pkg::NDC_FRAC){1'b0}}, num_a[l],
				{vmvp_pkg::NDC_FRAC{1'b0}}};
			q_s[0][l]   = '0;
			ovf_s[0][l] = 1'b0;
		end
	end

	// quotient = (num << 14) / den, one bit per stage, MSB first at weight 2^15
	for (genvar k = 0; k < S; k++) begin : g_step
		logic [DW-1:0] sh [3];
		logic [2:0]    ge;
		always_comb begin
			for (int l = 0; l < 3; l++) begin
				sh[l] = {{(S - 1){1'b0}}, den_s[k], 1'b0} << (S - 1 - k);
				ge[l] = rem_s[k][l] >= (sh[l] >> 1);
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end
		always_ff @(posedge clk) begin
			den_s[k+1] <= den_s[k];
			neg_s[k+1] <= neg_s[k];
			flt_s[k+1] <= flt_s[k];
			tex_s[k+1] <= tex_s[k];
			for (int l = 0; l < 3; l++) begin
				if (ge[l]) begin
					rem_s[k+1][l] <= rem_s[k][l] - (sh[l] >> 1);
				end else begin
					rem_s[k+1][l] <= rem_s[k][l];
				end
				q_s[k+1][l] <= {q_s[k][l][S-2:0], ge[l]};
				ovf_s[k+1][l] <= ovf_s[k][l];
			end
		end
	end

	// remainder still at least den after all steps: quotient at or beyond 2^16
	logic [2:0]        big;
	logic [2:0][15:0]  res;
	logic [2:0]        cl;
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			big[l] = (rem_s[S][l] >= {{S{1'b0}}, den_s[S]}) || ovf_s[S][l];
			cl[l]  = 1'b0;
			res[l] = '0;
			if (neg_s[S][l]) begin
				if (big[l] || (q_s[S][l] > 16'd32768)) begin
					cl[l]  = 1'b1;
					res[l] = 16'h8000;
				end else begin
					res[l] = 16'(~q_s[S][l] + 16'd1);
				end
			end else if (big[l] || q_s[S][l][15]) begin
				cl[l]  = 1'b1;
				res[l] = 16'h7FFF;
			end else begin
				res[l] = q_s[S][l];
			end
			if (flt_s[S]) begin
				res[l] = '0;
				cl[l]  = 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_s[S];
		end
	end
	always_ff @(posedge clk) begin
		ndc       <= res;
		sat       <= |cl;
		fault_out <= flt_s[S];
		tex_out   <= tex_s[S];
	end
endmodule
`default_nettype wire

[design/vertex_mvp_transform_perspective_divide.sv]
// Top level: MVP matrix transform followed by perspective divide.
// Usage:
//   Raise start with a vertex (pos_x/y/z, tex_u/v) while busy is low; busy
//   is always low, so a vertex may be requested every cycle.
//   The 4x4 matrix is loaded through cfg_valid/cfg_ready/cfg_index/cfg_data,
//   one 64-bit row per write; cfg_ready is always high. Indexes past row 3
//   are ignored. Write only while no vertex is in flight.
// Pipeline:
//   s1 registers the sixteen products, s2 the row sums, s3 magnitudes and
//   signs, then a 16-stage divider yields one quotient bit per stage, then
//   an output register: 20 register stages in all; throughput one vertex
//   per cycle, set by the fully pipelined divider.
//   done pulses one cycle with ndc_x/y/z, out_u/v, divide_fault, saturated.
//   The receiver cannot stall; results are dropped if not taken.
// Reset:
//   arst_n clears all valid bits and loads the identity matrix.
`default_nettype none
module vertex_mvp_transform_perspective_divide #(
	parameter int COORD_WIDTH = vmvp_pkg::COORD_WIDTH_DEF,
	parameter int COEF_WIDTH  = vmvp_pkg::COEF_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic signed [COORD_WIDTH-1:0] pos_x,
	input  wire logic signed [COORD_WIDTH-1:0] pos_y,
	input  wire logic signed [COORD_WIDTH-1:0] pos_z,
	input  wire logic [15:0]            tex_u,
	input  wire logic [15:0]            tex_v,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [1:0]             cfg_index,
	input  wire logic [63:0]            cfg_data,
	output logic                        done,
	output logic signed [15:0]          ndc_x,
	output logic signed [15:0]          ndc_y,
	output logic signed [15:0]          ndc_z,
	output logic [15:0]                 out_u,
	output logic [15:0]                 out_v,
	output logic                        divide_fault,
	output logic                        saturated
);
`include "assert_macros.svh"
	localparam int PW = COORD_WIDTH + COEF_WIDTH;
	localparam int SW = PW + 2;
	localparam int NW = SW;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// matrix registers
	logic [63:0] row_q [4];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= vmvp_pkg::ROW0_RST >> (16 - COEF_WIDTH);
			row_q[1] <= vmvp_pkg::ROW1_RST >> (16 - COEF_WIDTH);
			row_q[2] <= vmvp_pkg::ROW2_RST >> (16 - COEF_WIDTH);
			row_q[3] <= vmvp_pkg::ROW3_RST >> (16 - COEF_WIDTH);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				vmvp_pkg::REG_ROW0: row_q[0] <= cfg_data;
				vmvp_pkg::REG_ROW1: row_q[1] <= cfg_data;
				vmvp_pkg::REG_ROW2: row_q[2] <= cfg_data;
				vmvp_pkg::REG_ROW3: row_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// s1: sixteen products
	logic signed [COORD_WIDTH:0] p [4];
	always_comb begin
		p[3] = (COORD_WIDTH+1)'(1) <<< (COORD_WIDTH / 2);
		p[0] = {pos_x[COORD_WIDTH-1], pos_x};
		p[1] = {pos_y[COORD_WIDTH-1], pos_y};
		p[2] = {pos_z[COORD_WIDTH-1], pos_z};
	end
	logic              v_s1;
	logic signed [PW:0] prod_s1 [4][4];
	logic [31:0]       tex_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start && !busy;
	end
	always_ff @(posedge clk) begin
		tex_s1 <= {tex_v, tex_u};
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				prod_s1[r][c] <= (PW+1)'($signed(row_q[r][16*c +: COEF_WIDTH]))
					* (PW+1)'(p[c]);
			end
		end
	end

	// s2: row sums
	logic              v_s2;
	logic signed [SW-1:0] clip_s2 [4];
	logic [31:0]       tex_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		tex_s2 <= tex_s1;
		for (int r = 0; r < 4; r++) begin
			clip_s2[r] <= SW'(prod_s1[r][0]) + SW'(prod_s1[r][1])
				+ SW'(prod_s1[r][2]) + SW'(prod_s1[r][3]);
		end
	end

	// s3: magnitudes, signs, fault
	logic              v_s3;
	logic [NW-1:0]     mag_s3 [3];
	logic [NW-1:0]     den_s3;
	logic [2:0]        neg_s3;
	logic              flt_s3;
	logic [31:0]       tex_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		tex_s3 <= tex_s2;
		flt_s3 <= (clip_s2[3] == '0);
		den_s3 <= clip_s2[3][SW-1] ? NW'(-clip_s2[3]) : NW'(clip_s2[3]);
		for (int l = 0; l < 3; l++) begin
			mag_s3[l] <= clip_s2[l][SW-1] ? NW'(-clip_s2[l]) : NW'(clip_s2[l]);
			neg_s3[l] <= clip_s2[l][SW-1] ^ clip_s2[3][SW-1];
		end
	end

	logic [2:0][15:0] ndc;
	logic [31:0]      tex_o;
	vmvp_div #(.NUM_W(NW)) u_div (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s3), .num_a(mag_s3),
		.den(den_s3), .neg(neg_s3), .fault(flt_s3), .tex(tex_s3),
		.out_valid(done), .ndc(ndc), .sat(saturated),
		.fault_out(divide_fault), .tex_out(tex_o)
	);
	assign ndc_x = ndc[0];
	assign ndc_y = ndc[1];
	assign ndc_z = ndc[2];
	assign out_u = tex_o[15:0];
	assign out_v = tex_o[31:16];

	`ASSERT_IMPLY(a_fault_zero, clk, arst_n, done && divide_fault, (ndc_x == '0) && !saturated)
	`ASSERT_IMPLY(a_busy_low, clk, arst_n, 1'b1, !busy)
	`ASSERT_NEXT(a_s1_follow, clk, arst_n, v_s1, v_s2)
endmodule
`default_nettype wire
